@@ design/efb_pkg.sv @@
package efb_pkg;

  localparam int unsigned MaxPayloadDef = 1500;
  localparam int unsigned MinPayloadDef = 46;
  localparam int unsigned HdrBytes      = 14;

  localparam logic [31:0] CrcPoly    = 32'hEDB8_8320;
  localparam logic [31:0] CrcAllOnes = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        last_byte;
    logic [47:0] dest_mac;
    logic [15:0] ether_type;
  } efb_in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
    logic       length_error;
  } efb_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR,
    ST_PAD,
    ST_FCS
  } efb_state_e;

endpackage

@@ design/efb_crc_unit.sv @@
module efb_crc_unit
  import efb_pkg::*;
(
  input  logic [31:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [31:0] crc_o
);

  // Reflected CRC-32, one byte per pass, least significant bit first.
  always_comb begin
    logic [31:0] c;
    c = crc_i ^ {24'd0, byte_i};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

@@ design/ethernet_frame_builder_core.sv @@
// Ethernet transmit framer. Payload bytes come in one item at a time. The first item of a
// frame produces the 14-byte header (destination MAC and EtherType from that item, source
// MAC from the register), followed by the payload byte. The framer takes that item, sends the
// header and then the payload byte, and takes no new item until it is done. Other payload
// items go straight out, and one frame byte leaves per cycle while the output is taken. The
// last item also produces zero padding up to MinPayload bytes and the 4-byte FCS. The FCS is
// the reflected CRC-32 over header, payload and pad, sent least significant byte first. A
// payload item beyond MaxPayload produces a single error item instead, and the rest of that
// frame is discarded. The rate is set by the one CRC byte unit, which every header, payload
// and pad byte passes through, and by the single output register.
module ethernet_frame_builder_core
  import efb_pkg::*;
#(
  parameter int unsigned MaxPayload = MaxPayloadDef,
  parameter int unsigned MinPayload = MinPayloadDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [47:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  efb_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output efb_out_t    out_data_o
);

  localparam int unsigned CntMax = (MaxPayload > MinPayload) ? MaxPayload : MinPayload;
  localparam int unsigned CntW   = $clog2(CntMax + 1);
  localparam int unsigned HdrW   = HdrBytes * 8;
  localparam int unsigned IdxW   = $clog2(HdrBytes);

  efb_state_e        state_q, state_d;
  logic [47:0]       src_mac_q;
  logic [CntW-1:0]   count_q, count_d;
  logic [31:0]       crc_q, crc_d;
  logic              in_frame_q, in_frame_d;
  logic              dropping_q, dropping_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [HdrW-1:0]   hdr_q, hdr_d;
  logic [7:0]        byte_q, byte_d;
  logic              last_q, last_d;
  logic              out_valid_q, out_valid_d;
  efb_out_t          out_data_q, out_data_d;

  logic              advance;
  logic              accept;
  logic [7:0]        crc_byte;
  logic [31:0]       crc_next;
  logic [CntW-1:0]   count_inc;
  logic [31:0]       fcs;

  efb_crc_unit u_crc (
    .crc_i  (crc_q),
    .byte_i (crc_byte),
    .crc_o  (crc_next)
  );

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && advance;
  assign accept     = in_valid_i && in_ready_o;
  assign count_inc  = count_q + 1'b1;
  assign fcs        = ~crc_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    crc_d       = crc_q;
    in_frame_d  = in_frame_q;
    dropping_d  = dropping_q;
    idx_d       = idx_q;
    hdr_d       = hdr_q;
    byte_d      = byte_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    crc_byte    = 8'd0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          priority if (dropping_q) begin
            dropping_d = !in_data_i.last_byte;
          end else if (!in_frame_q) begin
            in_frame_d = 1'b1;
            count_d    = '0;
            crc_d      = CrcAllOnes;
            idx_d      = '0;
            hdr_d      = {in_data_i.dest_mac, src_mac_q, in_data_i.ether_type};
            byte_d     = in_data_i.payload_byte;
            last_d     = in_data_i.last_byte;
            state_d    = ST_HDR;
          end else if (count_q >= CntW'(MaxPayload)) begin
            out_valid_d = 1'b1;
            out_data_d  = '{frame_byte: 8'd0, frame_last: 1'b1, length_error: 1'b1};
            count_d     = '0;
            crc_d       = CrcAllOnes;
            in_frame_d  = 1'b0;
            dropping_d  = !in_data_i.last_byte;
          end else begin
            crc_byte    = in_data_i.payload_byte;
            crc_d       = crc_next;
            count_d     = count_inc;
            out_valid_d = 1'b1;
            out_data_d  = '{frame_byte: in_data_i.payload_byte, frame_last: 1'b0,
                            length_error: 1'b0};
            if (in_data_i.last_byte) begin
              state_d = (count_inc < CntW'(MinPayload)) ? ST_PAD : ST_FCS;
              idx_d   = '0;
            end
          end
        end
      end

      ST_HDR: begin
        if (advance) begin
          crc_byte    = hdr_q[HdrW-1 -: 8];
          crc_d       = crc_next;
          out_valid_d = 1'b1;
          out_data_d  = '{frame_byte: hdr_q[HdrW-1 -: 8], frame_last: 1'b0,
                          length_error: 1'b0};
          hdr_d       = hdr_q << 8;
          idx_d       = idx_q + 1'b1;
          if (idx_q == IdxW'(HdrBytes - 1)) begin
            // Header done: the held first payload byte goes out next from the pad state.
            state_d = ST_PAD;
            count_d = '0;
            idx_d   = '1;
          end
        end
      end

      ST_PAD: begin
        if (advance) begin
          if (idx_q == '1) begin
            // First payload byte of the frame, held since the header began.
            crc_byte    = byte_q;
            crc_d       = crc_next;
            count_d     = count_inc;
            out_valid_d = 1'b1;
            out_data_d  = '{frame_byte: byte_q, frame_last: 1'b0, length_error: 1'b0};
            idx_d       = '0;
            if (!last_q) begin
              state_d = ST_IDLE;
            end else if (count_inc >= CntW'(MinPayload)) begin
              state_d = ST_FCS;
            end
          end else begin
            crc_byte    = 8'd0;
            crc_d       = crc_next;
            count_d     = count_inc;
            out_valid_d = 1'b1;
            out_data_d  = '{frame_byte: 8'd0, frame_last: 1'b0, length_error: 1'b0};
            if (count_inc >= CntW'(MinPayload)) begin
              state_d = ST_FCS;
              idx_d   = '0;
            end
          end
        end
      end

      ST_FCS: begin
        if (advance) begin
          out_valid_d = 1'b1;
          out_data_d  = '{frame_byte: fcs[7:0], frame_last: (idx_q == IdxW'(3)),
                          length_error: 1'b0};
          crc_d       = {8'hFF, crc_q[31:8]};
          idx_d       = idx_q + 1'b1;
          if (idx_q == IdxW'(3)) begin
            count_d    = '0;
            crc_d      = CrcAllOnes;
            in_frame_d = 1'b0;
            idx_d      = '0;
            state_d    = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      src_mac_q   <= '0;
      count_q     <= '0;
      crc_q       <= CrcAllOnes;
      in_frame_q  <= 1'b0;
      dropping_q  <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      crc_q       <= crc_d;
      in_frame_q  <= in_frame_d;
      dropping_q  <= dropping_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        src_mac_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q      <= hdr_d;
    byte_q     <= byte_d;
    last_q     <= last_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
